FILE: rtl/pcp_pkg.sv
package pcp_pkg;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_PARTICLE = 1'b1;

    localparam logic [1:0] COL_EMPTY  = 2'd0;
    localparam logic [1:0] COL_SPHERE = 2'd1;
    localparam logic [1:0] COL_PLANE  = 2'd2;

    localparam logic [1:0] CFG_PARTICLE_RADIUS = 2'd0;
    localparam logic [1:0] CFG_FRICTION        = 2'd1;

    localparam logic [16:0] FRIC_ONE   = 17'd65536;
    localparam int          FRIC_SHIFT = 16;
    localparam logic [63:0] MAG_CLAMP  = 64'd1 << 60;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MSQ,
        S_SQ,
        S_SPH_TEST,
        S_SQRT,
        S_DIV,
        S_DIV_WAIT,
        S_PL,
        S_PL_TEST,
        S_PUSH,
        S_VN,
        S_NV,
        S_TF,
        S_MWAIT,
        S_NEXT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]         ctype;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [30:0]        radius;
    } slot_entry_t;

    typedef struct packed {
        logic               start;
        logic               use_frac;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [63:0]        prod_sat;
        logic signed [63:0] result;
    } mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/pcp_slot_mem.sv
module pcp_slot_mem
    import pcp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_entry_t   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output slot_entry_t   rdata
);

    slot_entry_t            entry_mem [DEPTH];
    slot_entry_t            rd_entry_reg;
    logic [DEPTH-1:0]       valid_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_entry_reg <= entry_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // a slot never written reads as empty
    always_comb
    begin
        rdata = rd_entry_reg;
        if (!rd_valid_reg)
        begin
            rdata.ctype = COL_EMPTY;
        end
    end

endmodule

FILE: rtl/pcp_mulq.sv
module pcp_mulq
    import pcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    logic               neg_reg;
    logic               frac_reg;
    logic [63:0]        a_mag_reg;
    logic [63:0]        b_mag_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    logic [63:0]        psat_reg;
    logic signed [63:0] res_reg;

    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [1:0]         step;
    logic [127:0]       pp_shifted;
    logic [63:0]        m_sat;
    logic [63:0]        r_round;
    logic [63:0]        r_clamp;

    // partial products: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_half = cnt_reg[1] ? a_mag_reg[63:32] : a_mag_reg[31:0];
    assign b_half = cnt_reg[0] ? b_mag_reg[63:32] : b_mag_reg[31:0];
    assign step   = 2'(cnt_reg - 3'd1);

    always_comb
    begin
        case (step)
            2'd0:    pp_shifted = 128'(pp_reg);
            2'd1:    pp_shifted = 128'(pp_reg) << 32;
            2'd2:    pp_shifted = 128'(pp_reg) << 32;
            default: pp_shifted = 128'(pp_reg) << 64;
        endcase
    end

    assign m_sat = (acc_reg[127:64] != 64'd0) ? {64{1'b1}} : acc_reg[63:0];

    always_comb
    begin
        if (frac_reg)
        begin
            r_round = (m_sat >> FRAC_BITS) + 64'(m_sat[FRAC_BITS-1]);
        end
        else
        begin
            r_round = (m_sat >> FRIC_SHIFT) + 64'(m_sat[FRIC_SHIFT-1]);
        end
        r_clamp = (r_round > MAG_CLAMP) ? MAG_CLAMP : r_round;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_mag_reg <= req.a[63] ? 64'(-req.a) : 64'(req.a);
            b_mag_reg <= req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_reg   <= req.a[63] ^ req.b[63];
            frac_reg  <= req.use_frac;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= 3'd3)
            begin
                pp_reg <= a_half * b_half;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
            if (cnt_reg == 3'd5)
            begin
                psat_reg <= m_sat;
                res_reg  <= neg_reg ? -$signed(r_clamp) : $signed(r_clamp);
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.prod_sat = psat_reg;
    assign rsp.result   = res_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");
`endif

endmodule

FILE: rtl/pcp_isqrt.sv
module pcp_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [32:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one result bit per cycle, two radicand bits per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[32:0];

endmodule

FILE: rtl/pcp_div.sv
module pcp_div
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [32:0]        num,
    input  logic [32:0]        den,
    output logic               done,
    output logic [FRAC_BITS:0] quo
);

    localparam int CW = $clog2(FRAC_BITS + 2);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [34:0]        rem_reg;
    logic [32:0]        den_reg;
    logic [FRAC_BITS:0] quo_reg;
    logic [34:0]        trial;
    logic               ge;

    // numerator never exceeds the divisor, so the first step takes it as is
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[33:0], 1'b0};
    assign ge    = trial >= 35'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 35'(num);
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial - 35'(den_reg) : trial;
            quo_reg <= {quo_reg[FRAC_BITS-1:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/particle_collider_projection.sv
// collider write item: accepted while idle, the slot is visible to the next particle
// particle item: passed straight through when attached; otherwise every slot is read
// and checked in turn, empty slots skipped, with fixed-point products in the shared
// multiplier, a square root and, off centre, a division per normal component on a sphere contact
// one item in flight at a time; the result register frees the input side early
// reset: collider table reads empty, particle radius 1.0, friction 0, no result
module particle_collider_projection
    import pcp_pkg::*;
#(
    parameter int MAX_COLLIDERS = 16,
    parameter int FRAC_BITS     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [3:0]         slot,
    input  logic [1:0]         collider_type,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic [30:0]        sphere_radius,
    input  logic               attached,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] prev_x,
    output logic signed [31:0] prev_y,
    output logic signed [31:0] prev_z,
    output logic [4:0]         contacts,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SLOT_W = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
    localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
    localparam logic [32:0] EPS_RAW =
        33'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    state_t             state_reg, state_next;
    state_t             op_reg, op_next;
    logic [1:0]         k_reg, k_next;
    logic [SLOT_W-1:0]  cnt_reg;
    logic               out_valid_reg;
    logic [30:0]        pr_reg;
    logic [16:0]        fric_reg;

    logic signed [31:0] p_reg [3];
    logic signed [31:0] q_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [32:0] v_reg [3];
    logic signed [31:0] n_reg [3];
    logic signed [63:0] t_reg;
    logic [32:0]        m_reg;
    logic [63:0]        msq_reg;
    logic [65:0]        sum_reg;
    logic signed [63:0] depth_reg;
    logic signed [63:0] acc_reg;
    logic [4:0]         hits_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [4:0]         contacts_reg;

    logic               accept;
    logic               fin_load;
    logic               mem_we;
    logic               mem_re;
    slot_entry_t        mem_wdata;
    slot_entry_t        slot_rd;
    mul_req_t           mreq;
    mul_rsp_t           mrsp;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [32:0]        sqrt_root;
    logic               div_start;
    logic               div_done;
    logic [FRAC_BITS:0] div_quo;
    logic signed [32:0] v_cur;

    assign accept    = in_valid && !in_stall;
    assign fin_load  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign v_cur     = $signed({p_reg[k_reg][31], p_reg[k_reg]})
                     - $signed({q_reg[k_reg][31], q_reg[k_reg]});

    assign mem_we = accept && (kind == KIND_WRITE) && (32'(slot) < MAX_COLLIDERS);
    always_comb
    begin
        mem_wdata.ctype  = (collider_type == COL_SPHERE || collider_type == COL_PLANE)
                         ? collider_type : COL_EMPTY;
        mem_wdata.px     = a_x;
        mem_wdata.py     = a_y;
        mem_wdata.pz     = a_z;
        mem_wdata.nx     = b_x;
        mem_wdata.ny     = b_y;
        mem_wdata.nz     = b_z;
        mem_wdata.radius = sphere_radius;
    end

    pcp_slot_mem #(
        .DEPTH (MAX_COLLIDERS),
        .AW    (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (SLOT_W'(slot)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg),
        .rdata (slot_rd)
    );

    pcp_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    pcp_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sum_reg[63:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    pcp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag33(d_reg[k_reg])),
        .den   (sqrt_root),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= S_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        k_next        = k_reg;
        mreq          = '0;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;
        mem_re        = 1'b0;
        in_stall      = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && kind == KIND_PARTICLE)
                begin
                    k_next     = 2'd0;
                    state_next = attached ? S_FINISH : S_READ;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                k_next = 2'd0;
                case (slot_rd.ctype)
                    COL_SPHERE: state_next = S_MSQ;
                    COL_PLANE:  state_next = S_PL;
                    default:    state_next = S_NEXT;
                endcase
            end
            S_MSQ:
            begin
                mreq.start = 1'b1;
                mreq.a     = 64'(m_reg);
                mreq.b     = 64'(m_reg);
                op_next    = state_reg;
                state_next = S_MWAIT;
            end
            S_SQ:
            begin
                mreq.start = 1'b1;
                mreq.a     = 64'(mag33(d_reg[k_reg]));
                mreq.b     = 64'(mag33(d_reg[k_reg]));
                op_next    = state_reg;
                state_next = S_MWAIT;
            end
            S_PL:
            begin
                mreq.start    = 1'b1;
                mreq.use_frac = 1'b1;
                mreq.a        = 64'(d_reg[k_reg]);
                mreq.b        = 64'(n_reg[k_reg]);
                op_next       = state_reg;
                state_next    = S_MWAIT;
            end
            S_PUSH:
            begin
                mreq.start    = 1'b1;
                mreq.use_frac = 1'b1;
                mreq.a        = 64'(n_reg[k_reg]);
                mreq.b        = depth_reg;
                op_next       = state_reg;
                state_next    = S_MWAIT;
            end
            S_VN:
            begin
                mreq.start    = 1'b1;
                mreq.use_frac = 1'b1;
                mreq.a        = 64'(v_cur);
                mreq.b        = 64'(n_reg[k_reg]);
                op_next       = state_reg;
                state_next    = S_MWAIT;
            end
            S_NV:
            begin
                mreq.start    = 1'b1;
                mreq.use_frac = 1'b1;
                mreq.a        = 64'(n_reg[k_reg]);
                mreq.b        = acc_reg;
                op_next       = state_reg;
                state_next    = S_MWAIT;
            end
            S_TF:
            begin
                mreq.start = 1'b1;
                mreq.a     = t_reg;
                mreq.b     = 64'(fric_reg);
                op_next    = state_reg;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mrsp.done)
                begin
                    case (op_reg)
                        S_MSQ:
                        begin
                            k_next     = 2'd0;
                            state_next = S_SQ;
                        end
                        S_SQ:
                        begin
                            k_next     = k_reg + 2'd1;
                            state_next = (k_reg == 2'd2) ? S_SPH_TEST : S_SQ;
                        end
                        S_PL:
                        begin
                            k_next     = k_reg + 2'd1;
                            state_next = (k_reg == 2'd2) ? S_PL_TEST : S_PL;
                        end
                        S_PUSH:
                        begin
                            if (k_reg == 2'd2)
                            begin
                                k_next     = 2'd0;
                                state_next = (fric_reg != 17'd0) ? S_VN : S_NEXT;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = S_PUSH;
                            end
                        end
                        S_VN:
                        begin
                            k_next     = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                            state_next = (k_reg == 2'd2) ? S_NV : S_VN;
                        end
                        S_NV:
                        begin
                            state_next = S_TF;
                        end
                        S_TF:
                        begin
                            k_next     = k_reg + 2'd1;
                            state_next = (k_reg == 2'd2) ? S_NEXT : S_NV;
                        end
                        default:
                        begin
                            state_next = S_NEXT;
                        end
                    endcase
                end
            end
            S_SPH_TEST:
            begin
                if (sum_reg >= 66'(msq_reg))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    k_next     = 2'd0;
                    state_next = (sqrt_root > EPS_RAW) ? S_DIV : S_PUSH;
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    k_next     = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? S_PUSH : S_DIV;
                end
            end
            S_PL_TEST:
            begin
                k_next     = 2'd0;
                state_next = (acc_reg >= $signed(64'(pr_reg))) ? S_NEXT : S_PUSH;
            end
            S_NEXT:
            begin
                state_next = (cnt_reg == SLOT_W'(MAX_COLLIDERS - 1)) ? S_FINISH : S_READ;
            end
            S_FINISH:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pr_reg        <= 31'd65536;
            fric_reg      <= 17'd0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_NEXT)
            begin
                cnt_reg <= cnt_reg + SLOT_W'(1);
            end

            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PARTICLE_RADIUS:
                    begin
                        pr_reg <= cfg_data[30:0];
                    end
                    CFG_FRICTION:
                    begin
                        fric_reg <= (cfg_data[16:0] > FRIC_ONE) ? FRIC_ONE : cfg_data[16:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && kind == KIND_PARTICLE)
                begin
                    p_reg[0] <= a_x;
                    p_reg[1] <= a_y;
                    p_reg[2] <= a_z;
                    q_reg[0] <= b_x;
                    q_reg[1] <= b_y;
                    q_reg[2] <= b_z;
                    hits_reg <= 5'd0;
                end
            end
            S_CHECK:
            begin
                d_reg[0] <= $signed({p_reg[0][31], p_reg[0]}) - $signed({slot_rd.px[31], slot_rd.px});
                d_reg[1] <= $signed({p_reg[1][31], p_reg[1]}) - $signed({slot_rd.py[31], slot_rd.py});
                d_reg[2] <= $signed({p_reg[2][31], p_reg[2]}) - $signed({slot_rd.pz[31], slot_rd.pz});
                n_reg[0] <= slot_rd.nx;
                n_reg[1] <= slot_rd.ny;
                n_reg[2] <= slot_rd.nz;
                m_reg    <= 33'(pr_reg) + 33'(slot_rd.radius);
                acc_reg  <= '0;
            end
            S_VN:
            begin
                v_reg[k_reg] <= v_cur;
            end
            S_MWAIT:
            begin
                if (mrsp.done)
                begin
                    case (op_reg)
                        S_MSQ:
                        begin
                            msq_reg <= mrsp.prod_sat;
                            sum_reg <= '0;
                        end
                        S_SQ:
                        begin
                            // squares are saturated, so an overflowing sum still fails the test
                            sum_reg <= sum_reg + 66'(mrsp.prod_sat);
                        end
                        S_PL, S_VN:
                        begin
                            acc_reg <= acc_reg + mrsp.result;
                        end
                        S_PUSH:
                        begin
                            p_reg[k_reg] <= sat32(64'(p_reg[k_reg]) + mrsp.result);
                            if (k_reg == 2'd2)
                            begin
                                acc_reg <= '0;
                                if (hits_reg != 5'd31)
                                begin
                                    hits_reg <= hits_reg + 5'd1;
                                end
                            end
                        end
                        S_NV:
                        begin
                            t_reg <= 64'(v_reg[k_reg]) - mrsp.result;
                        end
                        S_TF:
                        begin
                            q_reg[k_reg] <= sat32(64'(q_reg[k_reg]) + mrsp.result);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    depth_reg <= $signed(64'(m_reg) - 64'(sqrt_root));
                    if (!(sqrt_root > EPS_RAW))
                    begin
                        // centre hit: push along +x
                        n_reg[0] <= ONE_Q;
                        n_reg[1] <= 32'sd0;
                        n_reg[2] <= 32'sd0;
                    end
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    n_reg[k_reg] <= d_reg[k_reg][32] ? -$signed(32'(div_quo))
                                                     : $signed(32'(div_quo));
                end
            end
            S_PL_TEST:
            begin
                depth_reg <= $signed(64'(pr_reg)) - acc_reg;
            end
            S_FINISH:
            begin
                if (fin_load)
                begin
                    pos_x_reg    <= p_reg[0];
                    pos_y_reg    <= p_reg[1];
                    pos_z_reg    <= p_reg[2];
                    prev_x_reg   <= q_reg[0];
                    prev_y_reg   <= q_reg[1];
                    prev_z_reg   <= q_reg[2];
                    contacts_reg <= hits_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign prev_x    = prev_x_reg;
    assign prev_y    = prev_y_reg;
    assign prev_z    = prev_z_reg;
    assign contacts  = contacts_reg;

`ifndef SYNTHESIS
    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == S_CHECK))
        else $error("table read not followed by slot check");
    a_root_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT && sqrt_done) |-> (sqrt_root < m_reg))
        else $error("sphere distance not below contact radius");
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> out_valid_reg)
        else $error("finished item not presented");
`endif

endmodule

FILE: tb/sv/particle_collider_projection_checker.sv
module particle_collider_projection_checker
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic [3:0]         slot,
    input  logic [1:0]         collider_type,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic [30:0]        sphere_radius,
    input  logic               attached,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] prev_x,
    input  logic signed [31:0] prev_y,
    input  logic signed [31:0] prev_z,
    input  logic [4:0]         contacts,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] q [3];
        logic [4:0]         hits;
    } particle_t;

    localparam longint EPS_RAW = 64'd66 / 1000;

    logic [30:0]    prad;
    logic [16:0]    fric;
    logic [1:0]     tbl_type [16];
    longint         tbl_pos  [16][3];
    longint         tbl_norm [16][3];
    longint unsigned tbl_rad [16];
    particle_t      expected_q [$];

    function automatic longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rounded fixed-point product, magnitude clamped to 2^60
    function automatic longint fxmul(longint a, longint b, int sh);
        longint unsigned ma, mb, m, r;
        logic [127:0] full;
        ma = magn(a);
        mb = magn(b);
        full = 128'(ma) * 128'(mb);
        m = (full[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : full[63:0];
        r = (m >> sh) + ((m >> (sh - 1)) & 1);
        if (r > MAG_CLAMP) r = MAG_CLAMP;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic particle_t resolve_particle(longint pi [3], longint qi [3], logic att);
        particle_t res;
        longint p [3], q [3], n [3], d [3], v [3], depth, pl_dist, vn, t;
        longint unsigned m, sum, sq, a, rd;
        logic over;
        int hits;
        hits = 0;
        p = pi;
        q = qi;
        if (!att)
        begin
            for (int s = 0; s < 16; s++)
            begin
                if (tbl_type[s] == COL_EMPTY) continue;
                for (int i = 0; i < 3; i++) d[i] = p[i] - tbl_pos[s][i];
                if (tbl_type[s] == COL_SPHERE)
                begin
                    m = longint'(prad) + tbl_rad[s];
                    sum = 0;
                    over = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        a = magn(d[i]);
                        if (a >= m) begin over = 1; break; end
                        sq = a * a;
                        if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin over = 1; break; end
                        sum += sq;
                    end
                    if (over || sum >= m * m) continue;
                    rd = root64(sum);
                    depth = m - rd;
                    if (longint'(rd) > EPS_RAW)
                        for (int i = 0; i < 3; i++)
                        begin
                            t = (magn(d[i]) << 16) / rd;
                            n[i] = d[i] < 0 ? -t : t;
                        end
                    else
                    begin
                        n[0] = 65536; n[1] = 0; n[2] = 0;
                    end
                end
                else
                begin
                    n = tbl_norm[s];
                    pl_dist = fxmul(d[0], n[0], 16) + fxmul(d[1], n[1], 16)
                            + fxmul(d[2], n[2], 16);
                    if (pl_dist >= longint'(prad)) continue;
                    depth = longint'(prad) - pl_dist;
                end
                if (hits < 31) hits++;
                for (int i = 0; i < 3; i++) p[i] = sat(p[i] + fxmul(n[i], depth, 16));
                if (fric != 0)
                begin
                    for (int i = 0; i < 3; i++) v[i] = p[i] - q[i];
                    vn = fxmul(v[0], n[0], 16) + fxmul(v[1], n[1], 16) + fxmul(v[2], n[2], 16);
                    for (int i = 0; i < 3; i++)
                    begin
                        t = v[i] - fxmul(n[i], vn, 16);
                        q[i] = sat(q[i] + fxmul(t, longint'(fric), FRIC_SHIFT));
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            res.p[i] = p[i][31:0];
            res.q[i] = q[i][31:0];
        end
        res.hits = hits[4:0];
        return res;
    endfunction

    task automatic check_field(string name, longint exp_v, longint got);
        if (exp_v != got)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        particle_t e;
        longint pi [3], qi [3];
        if (!rst_n)
        begin
            prad <= 31'd65536;
            fric <= '0;
            for (int s = 0; s < 16; s++) tbl_type[s] = COL_EMPTY;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PARTICLE_RADIUS) prad <= cfg_data[30:0];
                else if (cfg_index == CFG_FRICTION)
                    fric <= (cfg_data[16:0] > FRIC_ONE) ? FRIC_ONE : cfg_data[16:0];
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_WRITE)
                begin
                    tbl_type[slot] = (collider_type == 2'd3) ? COL_EMPTY : collider_type;
                    tbl_pos[slot][0] = a_x; tbl_pos[slot][1] = a_y; tbl_pos[slot][2] = a_z;
                    tbl_norm[slot][0] = b_x; tbl_norm[slot][1] = b_y; tbl_norm[slot][2] = b_z;
                    tbl_rad[slot] = sphere_radius;
                end
                else
                begin
                    pi[0] = a_x; pi[1] = a_y; pi[2] = a_z;
                    qi[0] = b_x; qi[1] = b_y; qi[2] = b_z;
                    expected_q = {expected_q, resolve_particle(pi, qi, attached)};
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("pos_x", e.p[0], pos_x);
                    check_field("pos_y", e.p[1], pos_y);
                    check_field("pos_z", e.p[2], pos_z);
                    check_field("prev_x", e.q[0], prev_x);
                    check_field("prev_y", e.q[1], prev_y);
                    check_field("prev_z", e.q[2], prev_z);
                    check_field("contacts", e.hits, contacts);
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

FILE: tb/sv/tb_particle_collider_projection.sv
module tb_particle_collider_projection;
    import pcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               kind = 0;
    logic [3:0]         slot = 0;
    logic [1:0]         collider_type = 0;
    logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
    logic [30:0]        sphere_radius = 0;
    logic               attached = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] pos_x, pos_y, pos_z, prev_x, prev_y, prev_z;
    logic [4:0]         contacts;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    int                 errors, pending;
    int                 cycle = 0;
    bit                 hold_off = 0;
    bit                 sink_quiet = 0;

    localparam int CYCLE_LIMIT = 30000000;

    particle_collider_projection DUT (.*);
    particle_collider_projection_checker u_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off when requested, no stalls while quiet
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (sink_quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 9) < 3);
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            repeat ($urandom_range(2000, 4000)) @(posedge clk);
            hold_off = 1;
            repeat ($urandom_range(300, 800)) @(posedge clk);
            hold_off = 0;
            sink_quiet = 1;
            repeat ($urandom_range(200, 600)) @(posedge clk);
            sink_quiet = 0;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
        endcase
    endfunction

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else if ($urandom_range(0, 40) == 0)
            repeat ($urandom_range(10, 60)) @(posedge clk);
    endtask

    task automatic send(logic k, logic [3:0] s, logic [1:0] ct, logic [31:0] ax, logic [31:0] ay,
                        logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                        logic [30:0] rad, logic att);
        in_valid <= 1'b1;
        kind <= k; slot <= s; collider_type <= ct;
        a_x <= ax; a_y <= ay; a_z <= az; b_x <= bx; b_y <= by; b_z <= bz;
        sphere_radius <= rad; attached <= att;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(0, 3) == 0 || hold_off)
        begin
            in_valid <= 1'b0;
            gap();
        end
    endtask

    task automatic write_collider(logic [3:0] s, logic [1:0] ct);
        logic [31:0] n [3];
        int axis;
        axis = $urandom_range(0, 2);
        foreach (n[i]) n[i] = 0;
        n[axis] = $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
        if ($urandom_range(0, 4) == 0)
            foreach (n[i]) n[i] = rand_coord();
        send(KIND_WRITE, s, ct, rand_coord(), rand_coord(), rand_coord(), n[0], n[1], n[2],
             $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h30000)), 0);
    endtask

    task automatic send_particle(logic att);
        send(KIND_PARTICLE, 4'($urandom), 2'($urandom), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), 31'($urandom), att);
    endtask

    task automatic drain_and_config(logic [1:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty table, attached pass-through, zero-distance sphere, plane contact, type 3 clears
        send_particle(0);
        send(KIND_PARTICLE, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000,
             32'sh7fffffff, 32'hffffffff, 31'h7fffffff, 1);
        send(KIND_WRITE, 0, COL_SPHERE, 0, 0, 0, 0, 0, 0, 31'h10000, 0);
        send(KIND_PARTICLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_PARTICLE, 0, 0, 32'h8000, 32'h4000, 0, 0, 0, 0, 0, 0);
        send(KIND_WRITE, 1, COL_PLANE, 0, 0, 0, 0, 32'h10000, 0, 0, 0);
        send(KIND_PARTICLE, 0, 0, 32'h100, 32'hffff0000, 32'h200, 0, 32'h5, 0, 0, 0);
        send(KIND_WRITE, 2, COL_PLANE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_PARTICLE, 0, 0, 32'h40000, 32'h40000, 32'h40000, 0, 0, 0, 0, 0);
        send(KIND_WRITE, 0, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff, 31'h7fffffff, 0);
        send(KIND_WRITE, 2, COL_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0);
        send_particle(0);
        drain_and_config(CFG_FRICTION, 32'h1ffff);
        send(KIND_PARTICLE, 0, 0, 32'h100, 32'hffff8000, 0, 32'h30000, 32'h20000, 32'h1000, 0, 0);
        drain_and_config(CFG_PARTICLE_RADIUS, 32'hffffffff);
        send_particle(0);
        send(KIND_PARTICLE, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
             32'h80000000, 32'h80000000, 0, 0);
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: drain_and_config(CFG_PARTICLE_RADIUS, 32'h10000);
                1: drain_and_config(CFG_FRICTION, 32'h8000);
                2: drain_and_config(CFG_PARTICLE_RADIUS, 0);
                3: drain_and_config(CFG_FRICTION, $urandom);
                4: drain_and_config(CFG_PARTICLE_RADIUS, $urandom_range(0, 32'h40000));
                default: drain_and_config(CFG_FRICTION, 0);
            endcase
            for (int n = 0; n < 160; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_collider(4'($urandom),
                                   $urandom_range(0, 5) == 0 ? 2'($urandom)
                                                             : 2'($urandom_range(1, 2)));
                else
                    send_particle($urandom_range(0, 9) == 0);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
